### src/amnf_pkg.sv
// Shared types and constants for the adaptive mains notch filter.
// No dependencies; used by every module of the block.
package amnf_pkg;

    localparam int CHANNELS = 8;
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_W     = 3;
    localparam int SMP_W    = 16;
    localparam int DRIFT_W  = 6;
    localparam int ADDR_W   = 5;
    localparam int TDATA_W  = 24;

    localparam logic                 FILTER_ON_RST  = 1'b0;
    localparam logic [3:0]           ACTIVE_CH_RST  = 4'd3;
    localparam logic signed [15:0]   COEF_START_RST = 16'sd23206;
    localparam logic signed [15:0]   COEF_UPPER_RST = 16'sd23495;
    localparam logic signed [15:0]   COEF_LOWER_RST = 16'sd23061;

    // Drift counter trip level and the amount it falls back after a step
    localparam logic signed [DRIFT_W-1:0] DRIFT_LIMIT = 6'sd16;
    localparam logic signed [DRIFT_W-1:0] DRIFT_BACK  = 6'sd8;

    typedef enum logic [2:0] {
        REG_FILTER_ON  = 3'd0,
        REG_ACTIVE_CH  = 3'd1,
        REG_COEF_START = 3'd2,
        REG_COEF_UPPER = 3'd3,
        REG_COEF_LOWER = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic               filter_on;
        logic [3:0]         active_channels;
        logic signed [15:0] coef_upper;
        logic signed [15:0] coef_lower;
    } cfg_t;

    // Store clear request issued with every write to a defined register
    typedef struct packed {
        logic               clear;
        logic signed [15:0] coef_load;
    } clr_t;

    typedef struct packed {
        logic signed [15:0]        coef;
        logic signed [15:0]        noise_last;
        logic signed [15:0]        noise_prev;
        logic signed [15:0]        sample_last;
        logic signed [DRIFT_W-1:0] drift;
    } chan_state_t;

endpackage

### src/adaptive_mains_notch_filter_top.sv
// Adaptive mains notch filter: takes one sample per clock while not back-pressured
// and returns it with the tracked power-line tone removed, via the input register
// and then the update and result register. Throughput is one sample per cycle
// while the sink takes results, set by the single 17x16 multiply and the channel
// state read-modify-write, both combinational between the two registers. Each
// channel keeps its own oscillator state, so interleaved channels and repeats of
// the same channel run back to back. Any write to a defined register clears all
// channel state and reloads the start coefficient at once.
// Depends on amnf_pkg, amnf_cfg, amnf_store, amnf_calc.
module adaptive_mains_notch_filter_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [amnf_pkg::TDATA_W-1:0]  s_tdata,   // [2:0] channel, [18:3] sample
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [amnf_pkg::TDATA_W-1:0]  m_tdata,   // [2:0] out_channel, [18:3] filtered
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [amnf_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    amnf_pkg::cfg_t              cfg;
    amnf_pkg::clr_t              clr;
    amnf_pkg::chan_state_t       cur_state;
    amnf_pkg::chan_state_t       upd_state;

    logic                        in_valid_reg;
    logic [amnf_pkg::CH_W-1:0]   in_channel_reg;
    logic signed [15:0]          in_sample_reg;
    logic                        out_valid_reg;
    logic [amnf_pkg::CH_W-1:0]   out_channel_reg;
    logic signed [15:0]          out_filtered_reg;

    logic                        advance;
    logic                        calc_fire;
    logic                        active;
    logic signed [15:0]          filtered_next;
    logic [amnf_pkg::IDX_W-1:0]  ch_idx;

    amnf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .clr     (clr)
    );

    assign ch_idx = amnf_pkg::IDX_W'(in_channel_reg);

    amnf_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr      (clr),
        .rd_idx   (ch_idx),
        .rd_state (cur_state),
        .wr_en    (calc_fire && active),
        .wr_idx   (ch_idx),
        .wr_state (upd_state)
    );

    amnf_calc u_calc (
        .channel  (in_channel_reg),
        .sample   (in_sample_reg),
        .cfg      (cfg),
        .cur      (cur_state),
        .upd      (upd_state),
        .active   (active),
        .filtered (filtered_next)
    );

    assign advance   = !out_valid_reg || m_tready;
    assign calc_fire = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (calc_fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (calc_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_channel_reg <= s_tdata[amnf_pkg::CH_W-1:0];
            in_sample_reg  <= $signed(s_tdata[amnf_pkg::CH_W +: amnf_pkg::SMP_W]);
        end
        if (calc_fire)
        begin
            out_channel_reg  <= in_channel_reg;
            out_filtered_reg <= filtered_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(amnf_pkg::TDATA_W - amnf_pkg::CH_W - amnf_pkg::SMP_W){1'b0}},
                       out_filtered_reg, out_channel_reg};

    // With filtering off the sample must come out untouched
    a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        (calc_fire && !cfg.filter_on) |=>
            (m_tdata[amnf_pkg::CH_W +: amnf_pkg::SMP_W] == $past(in_sample_reg)))
        else $error("bypassed sample altered");

    // Drift counter settles back inside the trip band after every update
    a_drift_band: assert property (@(posedge clk) disable iff (!rst_n)
        (calc_fire && active) |->
            (upd_state.drift <= amnf_pkg::DRIFT_LIMIT
             && upd_state.drift >= -amnf_pkg::DRIFT_LIMIT))
        else $error("drift counter out of band");

    // Stored coefficient respects ordered clamps
    a_coef_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (calc_fire && active && cfg.coef_lower <= cfg.coef_upper) |->
            (upd_state.coef <= cfg.coef_upper && upd_state.coef >= cfg.coef_lower))
        else $error("coefficient outside clamps");

    // Input side only backs up when a finished result is held by the sink
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready && in_valid_reg))
        else $error("input stalled without output backpressure");

endmodule

### src/amnf_cfg.sv
// APB register file: enable, active channel count, coefficient start and clamps.
// Depends on amnf_pkg.
module amnf_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [amnf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output amnf_pkg::cfg_t              cfg,
    output amnf_pkg::clr_t              clr
);

    logic               filter_on_reg;
    logic [3:0]         active_channels_reg;
    logic signed [15:0] coef_start_reg;
    logic signed [15:0] coef_upper_reg;
    logic signed [15:0] coef_lower_reg;
    logic               wr_en;
    logic               known_reg;
    amnf_pkg::reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = amnf_pkg::reg_idx_t'(paddr[amnf_pkg::ADDR_W-1:2]);

    always_comb
    begin
        known_reg = 1'b1;
        prdata    = 32'd0;
        case (idx)
            amnf_pkg::REG_FILTER_ON:  prdata = {31'd0, filter_on_reg};
            amnf_pkg::REG_ACTIVE_CH:  prdata = {28'd0, active_channels_reg};
            amnf_pkg::REG_COEF_START: prdata = {16'd0, coef_start_reg};
            amnf_pkg::REG_COEF_UPPER: prdata = {16'd0, coef_upper_reg};
            amnf_pkg::REG_COEF_LOWER: prdata = {16'd0, coef_lower_reg};
            default:                  known_reg = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_on_reg       <= amnf_pkg::FILTER_ON_RST;
            active_channels_reg <= amnf_pkg::ACTIVE_CH_RST;
            coef_start_reg      <= amnf_pkg::COEF_START_RST;
            coef_upper_reg      <= amnf_pkg::COEF_UPPER_RST;
            coef_lower_reg      <= amnf_pkg::COEF_LOWER_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                amnf_pkg::REG_FILTER_ON:  filter_on_reg       <= pwdata[0];
                amnf_pkg::REG_ACTIVE_CH:  active_channels_reg <= pwdata[3:0];
                amnf_pkg::REG_COEF_START: coef_start_reg      <= pwdata[15:0];
                amnf_pkg::REG_COEF_UPPER: coef_upper_reg      <= pwdata[15:0];
                amnf_pkg::REG_COEF_LOWER: coef_lower_reg      <= pwdata[15:0];
                default:                  ;
            endcase
        end
    end

    assign cfg.filter_on       = filter_on_reg;
    assign cfg.active_channels = active_channels_reg;
    assign cfg.coef_upper      = coef_upper_reg;
    assign cfg.coef_lower      = coef_lower_reg;

    // Any write to a defined register restarts every channel
    assign clr.clear     = wr_en && known_reg;
    assign clr.coef_load = (idx == amnf_pkg::REG_COEF_START) ? $signed(pwdata[15:0])
                                                             : coef_start_reg;

endmodule

### src/amnf_store.sv
// Per-channel oscillator state: one read port, one write port, bulk clear.
// Depends on amnf_pkg.
module amnf_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  amnf_pkg::clr_t             clr,
    input  logic [amnf_pkg::IDX_W-1:0] rd_idx,
    output amnf_pkg::chan_state_t      rd_state,
    input  logic                       wr_en,
    input  logic [amnf_pkg::IDX_W-1:0] wr_idx,
    input  amnf_pkg::chan_state_t      wr_state
);

    amnf_pkg::chan_state_t state_reg [amnf_pkg::CHANNELS];

    assign rd_state = state_reg[rd_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < amnf_pkg::CHANNELS; i++)
            begin
                state_reg[i] <= '{coef: amnf_pkg::COEF_START_RST, default: '0};
            end
        end
        else if (clr.clear)
        begin
            for (int i = 0; i < amnf_pkg::CHANNELS; i++)
            begin
                state_reg[i] <= '{coef: clr.coef_load, default: '0};
            end
        end
        else if (wr_en)
        begin
            state_reg[wr_idx] <= wr_state;
        end
    end

endmodule

### src/amnf_calc.sv
// One-sample update of a channel's noise oscillator and the filtered output.
// Depends on amnf_pkg.
module amnf_calc (
    input  logic [amnf_pkg::CH_W-1:0]   channel,
    input  logic signed [15:0]          sample,
    input  amnf_pkg::cfg_t              cfg,
    input  amnf_pkg::chan_state_t       cur,
    output amnf_pkg::chan_state_t       upd,
    output logic                        active,
    output logic signed [15:0]          filtered
);

    logic signed [32:0]                   prod;
    logic signed [15:0]                   est_raw;
    logic signed [15:0]                   est_adj;
    logic signed [15:0]                   est_sh;
    logic signed [15:0]                   nl_sh;
    logic signed [17:0]                   err_w;
    logic signed [15:0]                   err;
    logic                                 err_pos;
    logic                                 err_neg;
    logic signed [amnf_pkg::DRIFT_W-1:0]  drift1;
    logic signed [amnf_pkg::DRIFT_W-1:0]  drift2;
    logic signed [15:0]                   c_step;
    logic signed [15:0]                   c_hi;
    logic signed [15:0]                   c_clamp;

    assign active = cfg.filter_on
                 && ({1'b0, channel} < cfg.active_channels)
                 && (32'(channel) < amnf_pkg::CHANNELS);

    // Oscillator prediction: (2*last*coef)>>15 - before_last, all wrapped to 16 bits
    assign prod    = $signed({cur.noise_last, 1'b0}) * cur.coef;
    assign est_raw = $signed(prod[30:15]) - cur.noise_prev;

    assign est_sh = est_raw >>> 3;
    assign nl_sh  = cur.noise_last >>> 3;
    assign err_w  = (18'(sample) - 18'(est_sh)) - (18'(cur.sample_last) - 18'(nl_sh));
    assign err    = $signed(err_w[15:0]);
    assign err_neg = err[15];
    assign err_pos = !err[15] && (err != 16'sd0);

    always_comb
    begin
        est_adj = est_raw;
        drift1  = cur.drift;
        if (err_pos)
        begin
            est_adj = est_raw + 16'sd1;
            drift1  = (est_adj > 16'sd0) ? cur.drift + 6'sd1 : cur.drift - 6'sd1;
        end
        else if (err_neg)
        begin
            est_adj = est_raw - 16'sd1;
            drift1  = (est_adj < 16'sd0) ? cur.drift + 6'sd1 : cur.drift - 6'sd1;
        end
    end

    always_comb
    begin
        c_step = cur.coef;
        drift2 = drift1;
        if (drift1 < -amnf_pkg::DRIFT_LIMIT)
        begin
            c_step = cur.coef - 16'sd1;
            drift2 = drift1 + amnf_pkg::DRIFT_BACK;
        end
        else if (drift1 > amnf_pkg::DRIFT_LIMIT)
        begin
            c_step = cur.coef + 16'sd1;
            drift2 = drift1 - amnf_pkg::DRIFT_BACK;
        end
    end

    // Upper clamp first; the lower clamp wins when the limits are inverted
    assign c_hi    = (c_step > cfg.coef_upper) ? cfg.coef_upper : c_step;
    assign c_clamp = (c_hi < cfg.coef_lower) ? cfg.coef_lower : c_hi;

    assign upd.coef        = c_clamp;
    assign upd.noise_last  = est_adj;
    assign upd.noise_prev  = cur.noise_last;
    assign upd.sample_last = sample;
    assign upd.drift       = drift2;

    assign filtered = active ? sample - (est_adj >>> 3) : sample;

endmodule
